>>> rtl/whcl_pkg.sv
package whcl_pkg;

   // byte position and chunk start span 33 bits so a chunk start cannot wrap
   localparam int unsigned POS_W = 33;
   localparam logic [POS_W-1:0] POS_MAX = 33'h1_FFFF_FFFF;
   localparam logic [POS_W-1:0] HDR_LEN = 33'd36;
   localparam logic [POS_W-1:0] CHUNK_FIRST_START = 33'd36;
   localparam int unsigned CHUNK_HDR_BYTES = 8;

   // shortest file lengths for the early length checks
   localparam logic [31:0] MIN_TOTAL_LEN = 32'd36;
   localparam logic [31:0] MIN_TOTAL_WITH_CHUNK = 32'd44;

   // four-character tags, first character in the low byte
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [7:0] FMT_PCM = 8'd1;
   localparam logic [7:0] BITS_PCM16 = 8'd16;

   // fixed header byte positions
   localparam logic [5:0] POS_RIFF_FIRST = 6'd0;
   localparam logic [5:0] POS_RIFF_LAST = 6'd3;
   localparam logic [5:0] POS_WAVE_FIRST = 6'd8;
   localparam logic [5:0] POS_WAVE_LAST = 6'd11;
   localparam logic [5:0] POS_FMT_LO = 6'd20;
   localparam logic [5:0] POS_FMT_HI = 6'd21;
   localparam logic [5:0] POS_CH_LO = 6'd22;
   localparam logic [5:0] POS_CH_HI = 6'd23;
   localparam logic [5:0] POS_RATE_FIRST = 6'd24;
   localparam logic [5:0] POS_RATE_LAST = 6'd27;
   localparam logic [5:0] POS_BITS_LO = 6'd34;
   localparam logic [5:0] POS_BITS_HI = 6'd35;

   // frame count divider
   localparam int unsigned DIV_STEPS = 32;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int unsigned DIVISOR_W = 17;

   // register map
   localparam int unsigned CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_TOTAL_LENGTH = 2'd0;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic load_out;
      logic out_reject;
   } ctrl_cmd_type;

   typedef struct packed {
      logic hit_reject;
      logic hit_found;
      logic div_done;
   } dpath_stat_type;

endpackage

>>> rtl/whcl_if.sv
interface whcl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;

   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface whcl_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [31:0] frame_count;
   logic [15:0] channel_count;
   logic [31:0] sample_rate;
   logic [31:0] data_offset;

   modport source (output valid, output status, output frame_count, output channel_count,
                   output sample_rate, output data_offset, input ready);
   modport sink (input valid, input status, input frame_count, input channel_count,
                 input sample_rate, input data_offset, output ready);
endinterface

>>> rtl/whcl_div.sv
module whcl_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [31:0]                         dividend,
   input  logic [whcl_pkg::DIVISOR_W-1:0]      divisor,
   output logic                                done,
   output logic [31:0]                         quotient
);

   // restoring division, one quotient bit per cycle
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [whcl_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [31:0]                      quo_ff, quo_in;
   logic [whcl_pkg::DIVISOR_W-1:0]   rem_ff, rem_in;
   logic [whcl_pkg::DIVISOR_W-1:0]   dvs_ff, dvs_in;
   logic [whcl_pkg::DIVISOR_W:0]     shifted;
   logic [whcl_pkg::DIVISOR_W:0]     trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      trial   = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], ~trial[whcl_pkg::DIVISOR_W]};
         rem_in = trial[whcl_pkg::DIVISOR_W] ? shifted[whcl_pkg::DIVISOR_W-1:0]
                                             : trial[whcl_pkg::DIVISOR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == whcl_pkg::DIV_CNT_W'(whcl_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/whcl_dpath.sv
module whcl_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  whcl_pkg::ctrl_cmd_type   cmd,
   output whcl_pkg::dpath_stat_type stat,
   input  logic [7:0]               data_byte,
   input  logic                     first_byte,
   input  logic [31:0]              total_length,
   output logic                     status,
   output logic [31:0]              frame_count,
   output logic [15:0]              channel_count,
   output logic [31:0]              sample_rate,
   output logic [31:0]              data_offset
);

   // parse state
   logic [whcl_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       hv_ff, hv_in;
   logic [15:0]                ch_ff, ch_in;
   logic [31:0]                rate_ff, rate_in;
   logic [whcl_pkg::POS_W-1:0] start_ff, start_in;
   logic [31:0]                tag_ff, tag_in;
   logic [31:0]                size_ff, size_in;
   logic                       fin_ff, fin_in;

   // state as seen by this word, after a restart
   logic [whcl_pkg::POS_W-1:0] pos_e, start_e;
   logic                       hv_e, fin_e;
   logic [15:0]                ch_e;
   logic [31:0]                rate_e, tag_e, size_e;

   logic                       in_hdr, in_chunk;
   logic [5:0]                 hp;
   logic                       hdr_bad, hv_new, hdr_rej;
   logic [15:0]                ch_new;
   logic [31:0]                rate_new, hdr_lane;
   logic [whcl_pkg::POS_W:0]   diff;
   logic [2:0]                 rel;
   logic [31:0]                chunk_lane, tag_new, size_new;
   logic                       last, is_data, missing_adv, chunk_rej, found;
   logic [whcl_pkg::POS_W-1:0] start_adv;

   logic                       div_done;
   logic [31:0]                quotient;

   logic                       status_ff;
   logic [31:0]                frame_ff, rate_out_ff, offset_ff;
   logic [15:0]                ch_out_ff;
   logic [whcl_pkg::POS_W-1:0] offset_full;

   always_comb begin
      pos_e   = first_byte ? '0 : pos_ff;
      hv_e    = first_byte ? 1'b1 : hv_ff;
      ch_e    = first_byte ? '0 : ch_ff;
      rate_e  = first_byte ? '0 : rate_ff;
      start_e = first_byte ? whcl_pkg::CHUNK_FIRST_START : start_ff;
      tag_e   = first_byte ? '0 : tag_ff;
      size_e  = first_byte ? '0 : size_ff;
      fin_e   = first_byte ? 1'b0 : fin_ff;
   end

   // fixed header checks and captures
   always_comb begin
      in_hdr   = pos_e < whcl_pkg::HDR_LEN;
      hp       = pos_e[5:0];
      hdr_lane = {24'd0, data_byte} << {hp[1:0], 3'b000};
      hdr_bad  = 1'b0;
      ch_new   = ch_e;
      rate_new = rate_e;
      case (hp) inside
         [whcl_pkg::POS_RIFF_FIRST:whcl_pkg::POS_RIFF_LAST]:
            hdr_bad = data_byte != whcl_pkg::TAG_RIFF[{hp[1:0], 3'b000} +: 8];
         [whcl_pkg::POS_WAVE_FIRST:whcl_pkg::POS_WAVE_LAST]:
            hdr_bad = data_byte != whcl_pkg::TAG_WAVE[{hp[1:0], 3'b000} +: 8];
         whcl_pkg::POS_FMT_LO:  hdr_bad = data_byte != whcl_pkg::FMT_PCM;
         whcl_pkg::POS_FMT_HI:  hdr_bad = data_byte != 8'd0;
         whcl_pkg::POS_CH_LO:   ch_new = ch_e | {8'd0, data_byte};
         whcl_pkg::POS_CH_HI:   ch_new = ch_e | {data_byte, 8'd0};
         [whcl_pkg::POS_RATE_FIRST:whcl_pkg::POS_RATE_LAST]:
            rate_new = rate_e | hdr_lane;
         whcl_pkg::POS_BITS_LO: hdr_bad = data_byte != whcl_pkg::BITS_PCM16;
         whcl_pkg::POS_BITS_HI: hdr_bad = data_byte != 8'd0;
         default:               hdr_bad = 1'b0;
      endcase
      hv_new  = hv_e & ~hdr_bad;
      hdr_rej = ((hp == whcl_pkg::POS_RIFF_FIRST) && (total_length < whcl_pkg::MIN_TOTAL_LEN))
             || ((hp == whcl_pkg::POS_BITS_HI)
                 && (!hv_new || (total_length < whcl_pkg::MIN_TOTAL_WITH_CHUNK)));
   end

   // chunk header walk
   always_comb begin
      diff       = {1'b0, pos_e} - {1'b0, start_e};
      in_chunk   = ~in_hdr & ~diff[whcl_pkg::POS_W] & (diff[whcl_pkg::POS_W-1:3] == '0);
      rel        = diff[2:0];
      chunk_lane = {24'd0, data_byte} << {rel[1:0], 3'b000};
      if (rel == 3'd0) begin
         tag_new  = chunk_lane;
         size_new = '0;
      end else if (!rel[2]) begin
         tag_new  = tag_e | chunk_lane;
         size_new = size_e;
      end else begin
         tag_new  = tag_e;
         size_new = size_e | chunk_lane;
      end
      last        = rel == 3'd7;
      is_data     = tag_new == whcl_pkg::TAG_DATA;
      start_adv   = start_e + whcl_pkg::POS_W'(whcl_pkg::CHUNK_HDR_BYTES) + {1'b0, size_new};
      missing_adv = ({1'b0, start_adv} + (whcl_pkg::POS_W + 1)'(whcl_pkg::CHUNK_HDR_BYTES))
                    > {2'b00, total_length};
      chunk_rej   = last & (is_data ? (ch_e == '0) : missing_adv);
      found       = last & is_data & (ch_e != '0);
   end

   always_comb begin
      stat.hit_reject = ~fin_e & (in_hdr ? hdr_rej : (in_chunk & chunk_rej));
      stat.hit_found  = ~fin_e & in_chunk & found;
      stat.div_done   = div_done;
   end

   always_comb begin
      pos_in   = (pos_e == whcl_pkg::POS_MAX) ? pos_e : pos_e + 1'b1;
      hv_in    = hv_e;
      ch_in    = ch_e;
      rate_in  = rate_e;
      start_in = start_e;
      tag_in   = tag_e;
      size_in  = size_e;
      fin_in   = fin_e;
      if (!fin_e) begin
         fin_in = stat.hit_reject | stat.hit_found;
         if (in_hdr) begin
            hv_in   = hv_new;
            ch_in   = ch_new;
            rate_in = rate_new;
         end else if (in_chunk) begin
            tag_in  = tag_new;
            size_in = size_new;
            if (last && !is_data) begin
               start_in = start_adv;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         hv_ff    <= 1'b1;
         ch_ff    <= '0;
         rate_ff  <= '0;
         start_ff <= whcl_pkg::CHUNK_FIRST_START;
         tag_ff   <= '0;
         size_ff  <= '0;
         fin_ff   <= 1'b0;
      end else if (cmd.accept) begin
         pos_ff   <= pos_in;
         hv_ff    <= hv_in;
         ch_ff    <= ch_in;
         rate_ff  <= rate_in;
         start_ff <= start_in;
         tag_ff   <= tag_in;
         size_ff  <= size_in;
         fin_ff   <= fin_in;
      end
   end

   whcl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (size_new),
      .divisor  ({ch_e, 1'b0}),
      .done     (div_done),
      .quotient (quotient)
   );

   // result word register
   assign offset_full = start_ff + whcl_pkg::POS_W'(whcl_pkg::CHUNK_HDR_BYTES);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (cmd.out_reject) begin
            status_ff   <= 1'b1;
            frame_ff    <= '0;
            ch_out_ff   <= '0;
            rate_out_ff <= '0;
            offset_ff   <= '0;
         end else begin
            status_ff   <= 1'b0;
            frame_ff    <= quotient;
            ch_out_ff   <= ch_ff;
            rate_out_ff <= rate_ff;
            offset_ff   <= offset_full[31:0];
         end
      end
   end

   assign status        = status_ff;
   assign frame_count   = frame_ff;
   assign channel_count = ch_out_ff;
   assign sample_rate   = rate_out_ff;
   assign data_offset   = offset_ff;

endmodule

>>> rtl/whcl_ctrl.sv
module whcl_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output whcl_pkg::ctrl_cmd_type   cmd,
   input  whcl_pkg::dpath_stat_type stat
);

   typedef enum logic {
      ST_RUN,
      ST_DIVIDE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      req_ready      = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_ready);
      cmd.accept     = req_ready && req_valid;
      cmd.div_start  = cmd.accept && stat.hit_found;
      cmd.out_reject = state_ff == ST_RUN;
      cmd.load_out   = (cmd.accept && stat.hit_reject)
                    || ((state_ff == ST_DIVIDE) && stat.div_done);
      rsp_valid_in   = cmd.load_out || (rsp_valid_ff && !rsp_ready);
      state_in       = state_ff;
      unique case (state_ff)
         ST_RUN:    if (cmd.div_start) state_in = ST_DIVIDE;
         ST_DIVIDE: if (stat.div_done) state_in = ST_RUN;
         default:   state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/wave_header_chunk_locator_core.sv
// wav header parser and data chunk locator
// req_chan: one file byte per word (data_byte), first_byte high on byte zero
//   of each file restarts the parse
// rsp_chan: at most one word per file; status 0 gives frame count, channels,
//   sample rate and data offset of the first data chunk, status 1 means the
//   file was rejected (short file, bad header, missing chunk, zero channels)
//   with every other field zero
// apb port: total_length at byte address 0, to be written by the user only
//   while no file is in flight; the block itself does not enforce this
// throughput: one byte per cycle while parsing; bytes after a result are
//   taken and dropped until the next first_byte
// results: a reject word shows in the cycle after its byte; a data chunk word
//   waits on the one-bit-per-cycle frame count divider, no byte taken meanwhile
// stall: the result word waits in its output register and no byte is taken
//   while it is held; a byte can be taken at the edge where the word leaves
// reset: parse restarts as if a file began, total_length clears, no word is
//   pending
module wave_header_chunk_locator_core (
   input  logic                                clock,
   input  logic                                reset,
   whcl_req_if.sink                            req_chan,
   whcl_rsp_if.source                          rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [whcl_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   // file length register
   logic [31:0]               total_length_ff;
   logic                      csr_wr;

   // controller to datapath
   whcl_pkg::ctrl_cmd_type    cmd;
   whcl_pkg::dpath_stat_type  stat;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready
                && (paddr == whcl_pkg::CSR_ADDR_TOTAL_LENGTH);
   assign prdata = (paddr == whcl_pkg::CSR_ADDR_TOTAL_LENGTH) ? total_length_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_length_ff <= '0;
      end else if (csr_wr) begin
         total_length_ff <= pwdata;
      end
   end

   // sequencing: byte acceptance, divide wait, result word hold
   whcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // parse state, chunk walk, divider and result word
   whcl_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .data_byte     (req_chan.data_byte),
      .first_byte    (req_chan.first_byte),
      .total_length  (total_length_ff),
      .status        (rsp_chan.status),
      .frame_count   (rsp_chan.frame_count),
      .channel_count (rsp_chan.channel_count),
      .sample_rate   (rsp_chan.sample_rate),
      .data_offset   (rsp_chan.data_offset)
   );

endmodule

>>> tb/sv/tb_wave_header_chunk_locator_core.sv
`timescale 1ns / 1ps

module tb_wave_header_chunk_locator_core;

   // result status codes
   localparam logic STATUS_FOUND    = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   // tags used to build files, first character in the low byte
   localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
   localparam logic [31:0] TAG_LIST = 32'h5453_494c;

   localparam int CYCLE_LIMIT       = 600000;
   localparam int LONG_STALL_CYCLES = 600;
   // settle outlasts the divide that a data chunk word waits on after its last header byte
   localparam int SETTLE_CYCLES     = 40;

   typedef struct packed {
      logic        status;
      logic [31:0] frame_count;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [31:0] data_offset;
   } locate_word_type;

   typedef struct {
      logic [7:0] value;
      logic       first;
   } stream_byte_type;

   logic clock = 1'b0;
   logic reset;

   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [whcl_pkg::CSR_ADDR_W-1:0] paddr;
   logic [31:0]                     pwdata;
   logic [31:0]                     prdata;
   logic                            pready;

   whcl_req_if req_bus ();
   whcl_rsp_if rsp_bus ();

   wave_header_chunk_locator_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #5 clock = ~clock;

   // bytes waiting to be offered and locate words still to come back
   stream_byte_type file_bytes[$];
   locate_word_type expected_locations[$];

   // parser shadow state, updated on every accepted word
   logic [31:0] total_len;
   logic [32:0] parse_pos;
   logic        header_ok;
   logic [15:0] wav_channels;
   logic [31:0] wav_rate;
   logic [32:0] chunk_base;
   logic [31:0] chunk_id;
   logic [31:0] chunk_len;
   logic        parse_done;

   int mismatches = 0;
   int cycle_count = 0;

   // idle control; the gap percentages are written by the stimulus process at falling edges
   int   send_gap_pct = 0;
   int   recv_gap_pct = 0;
   int   send_gap;
   int   recv_gap;
   logic long_stall = 1'b0;
   event long_stall_go;

   // every byte queued for sending
   int sent_bytes = 0;

   // ---------------------------------------------------------------------------------
   // parser prediction
   // ---------------------------------------------------------------------------------

   function automatic void restart_wav_parse();
      parse_pos    = '0;
      header_ok    = 1'b1;
      wav_channels = '0;
      wav_rate     = '0;
      chunk_base   = whcl_pkg::CHUNK_FIRST_START;
      chunk_id     = '0;
      chunk_len    = '0;
      parse_done   = 1'b0;
   endfunction

   // rejected word carries zeros in every other field
   function automatic void reject_wav();
      locate_word_type r;
      r = '0;
      r.status = STATUS_REJECTED;
      expected_locations.push_back(r);
      parse_done = 1'b1;
   endfunction

   // next chunk header would run past the end of the file
   function automatic logic chunk_missing();
      return ({1'b0, chunk_base} + 34'd8) > {2'b00, total_len};
   endfunction

   function automatic void track_wav_byte(input logic [7:0] b, input logic first);
      logic [32:0]     p;
      logic [5:0]      hp;
      logic [2:0]      rel;
      logic [16:0]     divisor;
      locate_word_type r;
      if (first) restart_wav_parse();
      p = parse_pos;
      hp = p[5:0];
      // position saturates instead of wrapping
      if (parse_pos != whcl_pkg::POS_MAX) parse_pos = parse_pos + 33'd1;
      // after a result everything is dropped until the next byte zero
      if (parse_done) return;

      if (p < whcl_pkg::HDR_LEN) begin
         // short file is rejected on byte zero
         if (p == 0 && total_len < whcl_pkg::MIN_TOTAL_LEN) begin
            reject_wav();
            return;
         end
         if (hp <= whcl_pkg::POS_RIFF_LAST) begin
            if (b != whcl_pkg::TAG_RIFF[8*hp[1:0] +: 8]) header_ok = 1'b0;
         end else if (hp >= whcl_pkg::POS_WAVE_FIRST && hp <= whcl_pkg::POS_WAVE_LAST) begin
            if (b != whcl_pkg::TAG_WAVE[8*hp[1:0] +: 8]) header_ok = 1'b0;
         end else if (hp == whcl_pkg::POS_FMT_LO) begin
            if (b != whcl_pkg::FMT_PCM) header_ok = 1'b0;
         end else if (hp == whcl_pkg::POS_FMT_HI) begin
            if (b != 8'd0) header_ok = 1'b0;
         end else if (hp == whcl_pkg::POS_CH_LO) begin
            wav_channels = wav_channels | {8'h00, b};
         end else if (hp == whcl_pkg::POS_CH_HI) begin
            wav_channels = wav_channels | {b, 8'h00};
         end else if (hp >= whcl_pkg::POS_RATE_FIRST && hp <= whcl_pkg::POS_RATE_LAST) begin
            wav_rate = wav_rate | (32'(b) << (8*hp[1:0]));
         end else if (hp == whcl_pkg::POS_BITS_LO) begin
            if (b != whcl_pkg::BITS_PCM16) header_ok = 1'b0;
         end else if (hp == whcl_pkg::POS_BITS_HI) begin
            if (b != 8'd0) header_ok = 1'b0;
         end
         // last header byte: header checks and room for the first chunk
         if (hp == whcl_pkg::POS_BITS_HI && (!header_ok || chunk_missing())) reject_wav();
         return;
      end

      // only the 8-byte chunk headers matter, chunk bodies are skipped
      if (p >= chunk_base && {1'b0, p} < {1'b0, chunk_base} + 34'd8) begin
         rel = 3'(p - chunk_base);
         if (rel == 3'd0) begin
            chunk_id  = '0;
            chunk_len = '0;
         end
         if (!rel[2]) chunk_id = chunk_id | (32'(b) << (8*rel[1:0]));
         else chunk_len = chunk_len | (32'(b) << (8*rel[1:0]));
         if (rel == 3'd7) begin
            if (chunk_id == whcl_pkg::TAG_DATA) begin
               if (wav_channels == 16'd0) begin
                  reject_wav();
               end else begin
                  divisor = {wav_channels, 1'b0};
                  r.status        = STATUS_FOUND;
                  r.frame_count   = chunk_len / 32'(divisor);
                  r.channel_count = wav_channels;
                  r.sample_rate   = wav_rate;
                  r.data_offset   = 32'(chunk_base + 33'd8);
                  expected_locations.push_back(r);
                  parse_done = 1'b1;
               end
            end else begin
               // 33-bit start cannot wrap, an overflow shows up as a missing chunk
               chunk_base = chunk_base + 33'd8 + {1'b0, chunk_len};
               if (chunk_missing()) reject_wav();
            end
         end
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // monitor: apb shadow, result check, prediction of accepted bytes
   // ---------------------------------------------------------------------------------

   always @(posedge clock) begin
      locate_word_type got;
      locate_word_type want;
      if (reset) begin
         total_len = '0;
         restart_wav_parse();
      end else begin
         // apb access phase
         if (psel && penable && pready) begin
            if (pwrite) begin
               total_len = pwdata;
            end else if (prdata !== total_len) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("total_length readback: expected %h got %h", total_len, prdata);
            end
         end

         // result side first so a word is never matched to a byte taken at this edge
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status        = rsp_bus.status;
            got.frame_count   = rsp_bus.frame_count;
            got.channel_count = rsp_bus.channel_count;
            got.sample_rate   = rsp_bus.sample_rate;
            got.data_offset   = rsp_bus.data_offset;
            if (expected_locations.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: status %0d frames %0d ch %0d rate %0d off %0d",
                           got.status, got.frame_count, got.channel_count,
                           got.sample_rate, got.data_offset);
            end else begin
               want = expected_locations.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"word mismatch: expected status %0d frames %0d ch %0d rate %0d ",
                               "off %0d, got status %0d frames %0d ch %0d rate %0d off %0d"},
                              want.status, want.frame_count, want.channel_count,
                              want.sample_rate, want.data_offset, got.status,
                              got.frame_count, got.channel_count, got.sample_rate,
                              got.data_offset);
               end
            end
         end

         if (req_bus.valid && req_bus.ready)
            track_wav_byte(req_bus.data_byte, req_bus.first_byte);
      end
   end

   // ---------------------------------------------------------------------------------
   // byte driver: holds a word until taken, random idle bursts between words
   // ---------------------------------------------------------------------------------

   always @(posedge clock) begin
      stream_byte_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap != 0) begin
            req_bus.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (file_bytes.size() != 0 && send_gap_pct != 0 &&
                      $urandom_range(0, 99) < send_gap_pct) begin
            // idle burst, its length drawn at random
            req_bus.valid <= 1'b0;
            send_gap <= $urandom_range(0, 9);
         end else if (file_bytes.size() != 0) begin
            nxt = file_bytes.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.data_byte  <= nxt.value;
            req_bus.first_byte <= nxt.first;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // result receiver: random stall bursts, plus the long hold-off when asked
   // ---------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_gap <= 0;
      end else if (long_stall) begin
         rsp_bus.ready <= 1'b0;
      end else if (recv_gap != 0) begin
         rsp_bus.ready <= 1'b0;
         recv_gap <= recv_gap - 1;
      end else if (recv_gap_pct != 0 && $urandom_range(0, 99) < recv_gap_pct) begin
         rsp_bus.ready <= 1'b0;
         recv_gap <= $urandom_range(0, 9);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // long hold-off, counted here so the sender keeps offering bytes meanwhile
   always begin
      @(long_stall_go);
      long_stall = 1'b1;
      repeat (LONG_STALL_CYCLES) @(negedge clock);
      long_stall = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // file builders
   // ---------------------------------------------------------------------------------

   task automatic push_file_byte(input logic [7:0] value, input logic first);
      stream_byte_type sb;
      sb.value = value;
      sb.first = first;
      file_bytes.push_back(sb);
      sent_bytes++;
   endtask

   // fixed 36-byte header; bad_pos >= 0 corrupts that byte, [from, upto) is what gets sent
   task automatic push_header(input logic first_mark, input logic [15:0] chans,
                              input logic [31:0] rate, input int bad_pos,
                              input int from, input int upto);
      logic [7:0] hdr [36];
      for (int i = 0; i < 36; i++) hdr[i] = 8'($urandom);
      for (int k = 0; k < 4; k++) begin
         hdr[k]      = whcl_pkg::TAG_RIFF[8*k +: 8];
         hdr[8 + k]  = whcl_pkg::TAG_WAVE[8*k +: 8];
         hdr[12 + k] = TAG_FMT[8*k +: 8];
         hdr[16 + k] = (k == 0) ? 8'd16 : 8'd0;
         hdr[24 + k] = rate[8*k +: 8];
      end
      hdr[whcl_pkg::POS_FMT_LO]  = whcl_pkg::FMT_PCM;
      hdr[whcl_pkg::POS_FMT_HI]  = 8'd0;
      hdr[whcl_pkg::POS_CH_LO]   = chans[7:0];
      hdr[whcl_pkg::POS_CH_HI]   = chans[15:8];
      hdr[whcl_pkg::POS_BITS_LO] = whcl_pkg::BITS_PCM16;
      hdr[whcl_pkg::POS_BITS_HI] = 8'd0;
      if (bad_pos >= 0) hdr[bad_pos] ^= 8'($urandom_range(1, 255));
      for (int i = from; i < upto; i++) push_file_byte(hdr[i], first_mark && i == from);
   endtask

   // chunk header plus body bytes
   task automatic push_chunk(input logic [31:0] tag, input logic [31:0] len, input int body);
      for (int k = 0; k < 4; k++) push_file_byte(tag[8*k +: 8], 1'b0);
      for (int k = 0; k < 4; k++) push_file_byte(len[8*k +: 8], 1'b0);
      for (int k = 0; k < body; k++) push_file_byte(8'($urandom), 1'b0);
   endtask

   // mostly well-formed files with random content, some broken or truncated
   task automatic push_random_files(input int count);
      int          keep;
      int          bad;
      int          n_skip;
      int          body;
      logic        open;
      logic [15:0] ch;
      logic [31:0] rt;
      logic [31:0] tag;
      logic [31:0] len;
      for (int f = 0; f < count; f++) begin
         case ($urandom_range(0, 15))
            0:       ch = 16'd0;
            1:       ch = 16'hFFFF;
            2:       ch = 16'($urandom);
            default: ch = 16'($urandom_range(1, 8));
         endcase
         rt   = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(8000, 96000));
         bad  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 35) : -1;
         keep = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 35) : 36;
         push_header(1'b1, ch, rt, bad, 0, keep);
         open = (keep == 36);
         n_skip = $urandom_range(0, 3);
         for (int k = 0; k < n_skip && open; k++) begin
            // some skip tags differ from the data tag by a single bit
            tag = ($urandom_range(0, 3) == 0)
                  ? whcl_pkg::TAG_DATA ^ (32'h1 << $urandom_range(0, 31))
                  : $urandom;
            if (tag == whcl_pkg::TAG_DATA) tag = TAG_LIST;
            if ($urandom_range(0, 11) == 0) begin
               // huge skip: either missing chunk or a file cut short
               len  = $urandom | 32'h8000_0000;
               body = 0;
               open = 1'b0;
            end else begin
               len  = $urandom_range(0, 24);
               body = len;
            end
            push_chunk(tag, len, body);
         end
         if (open) begin
            len = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4096);
            push_chunk(whcl_pkg::TAG_DATA, len, $urandom_range(0, 3));
         end
         // stray bytes without a file start
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 6)) push_file_byte(8'($urandom), 1'b0);
         end
      end
   endtask

   // ---------------------------------------------------------------------------------
   // phase control
   // ---------------------------------------------------------------------------------

   // wait until every byte is taken and every word is back, then let the block go quiet
   task automatic settle();
      @(negedge clock);
      while (file_bytes.size() != 0 || req_bus.valid || expected_locations.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // apb write of total_length followed by a readback
   task automatic set_total_length(input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= whcl_pkg::CSR_ADDR_TOTAL_LENGTH; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic start_phase(input logic [31:0] len, input int send_pct, input int recv_pct);
      settle();
      send_gap_pct = send_pct;
      recv_gap_pct = recv_pct;
      set_total_length(len);
   endtask

   // ---------------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------------

   initial begin
      int          bad_spots [4];
      logic [31:0] len;
      logic        pressure_done;
      bad_spots = '{whcl_pkg::POS_RIFF_LAST, 10, whcl_pkg::POS_FMT_LO, whcl_pkg::POS_BITS_HI};
      pressure_done = 1'b0;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.data_byte = 8'd0;
      req_bus.first_byte = 1'b0;
      rsp_bus.ready = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: largest length, well-formed and broken files
      start_phase(32'hFFFF_FFFF, 0, 0);
      // no first_byte after reset, parse runs as if a file started
      push_header(1'b0, 16'd2, 32'd44100, -1, 0, 36);
      push_chunk(TAG_LIST, 32'd4, 4);
      push_chunk(whcl_pkg::TAG_DATA, 32'd1000, 2);
      // field extremes
      push_header(1'b1, 16'hFFFF, 32'hFFFF_FFFF, -1, 0, 36);
      push_chunk(whcl_pkg::TAG_DATA, 32'hFFFF_FFFF, 2);
      push_header(1'b1, 16'd1, 32'd0, -1, 0, 36);
      push_chunk(whcl_pkg::TAG_DATA, 32'd0, 1);
      // zero channels on a data chunk
      push_header(1'b1, 16'd0, 32'd48000, -1, 0, 36);
      push_chunk(whcl_pkg::TAG_DATA, 32'd64, 0);
      // bad riff, wave, format and bits fields
      foreach (bad_spots[i]) begin
         push_header(1'b1, 16'd2, 32'd8000, bad_spots[i], 0, 36);
         push_chunk(whcl_pkg::TAG_DATA, 32'd16, 0);
      end
      // near-miss tag skipped, then the real data chunk
      push_header(1'b1, 16'd2, 32'd22050, -1, 0, 36);
      push_chunk(whcl_pkg::TAG_DATA ^ 32'h0100_0000, 32'd0, 0);
      push_chunk(whcl_pkg::TAG_DATA, 32'd400, 0);
      // chunk start pushed past the 32-bit range, and to the last possible start
      push_header(1'b1, 16'd2, 32'd8000, -1, 0, 36);
      push_chunk(TAG_LIST, 32'hFFFF_FFFF, 0);
      push_header(1'b1, 16'd2, 32'd8000, -1, 0, 36);
      push_chunk(TAG_LIST, 32'hFFFF_FFCB, 0);
      // file cut short by a new byte zero
      push_header(1'b1, 16'd2, 32'd8000, -1, 0, 30);
      push_header(1'b1, 16'd3, 32'd11025, -1, 0, 36);
      push_chunk(whcl_pkg::TAG_DATA, 32'd600, 0);

      // length extremes around the header and first chunk
      start_phase(32'd0, 0, 0);
      push_header(1'b1, 16'd2, 32'd8000, -1, 0, 36);
      start_phase(32'd35, 0, 0);
      push_header(1'b1, 16'd2, 32'd8000, -1, 0, 36);
      start_phase(32'd36, 0, 0);
      push_header(1'b1, 16'd2, 32'd8000, -1, 0, 36);
      start_phase(32'd43, 0, 0);
      push_header(1'b1, 16'd2, 32'd8000, -1, 0, 36);
      start_phase(whcl_pkg::MIN_TOTAL_WITH_CHUNK, 0, 0);
      push_header(1'b1, 16'd2, 32'd8000, -1, 0, 36);
      push_chunk(whcl_pkg::TAG_DATA, 32'd0, 0);
      push_header(1'b1, 16'd2, 32'd8000, -1, 0, 36);
      push_chunk(TAG_LIST, 32'd0, 0);

      // length changed in the middle of a header
      start_phase(32'd1000, 0, 0);
      push_header(1'b1, 16'd2, 32'd8000, -1, 0, 20);
      start_phase(32'd40, 0, 0);
      push_header(1'b0, 16'd2, 32'd8000, -1, 20, 36);

      // random phases, one of them with the receiver held off for a long stretch
      while (sent_bytes < 1450 || !pressure_done) begin
         if (!pressure_done && sent_bytes >= 1000) begin
            start_phase(32'hFFFF_FFFF, 0, 0);
            -> long_stall_go;
            push_random_files(6);
            pressure_done = 1'b1;
         end else begin
            case ($urandom_range(0, 9))
               0:       len = $urandom_range(0, 60);
               1, 2:    len = $urandom_range(36, 250);
               3:       len = 32'hFFFF_FFFF;
               default: len = $urandom_range(250, 32'hFFFF_FFFF);
            endcase
            start_phase(len, 15 * $urandom_range(0, 3), 15 * $urandom_range(0, 3));
            push_random_files($urandom_range(2, 5));
         end
      end

      // last stretch without idling on either side
      start_phase(32'hFFFF_FFFF, 0, 0);
      push_random_files(4);
      settle();
      repeat (20) @(negedge clock);

      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> files.f
rtl/whcl_pkg.sv
rtl/whcl_if.sv
rtl/whcl_div.sv
rtl/whcl_dpath.sv
rtl/whcl_ctrl.sv
rtl/wave_header_chunk_locator_core.sv
tb/sv/tb_wave_header_chunk_locator_core.sv
